>>> design/hvpg_pkg.sv
// Shared types and constants for the haptic vibration pattern generator.
// Used by hvpg_cfg, hvpg_core and the top level; no dependencies.
`timescale 1ns / 1ps
package hvpg_pkg;

    localparam int PAT_W    = 3;
    localparam int PERIOD_W = 7;
    localparam int TICK_W   = 8;
    localparam int PULSE_W  = 2;
    localparam int CFG_IDX_W = 8;
    localparam int THR_W    = 9;

    // pattern codes
    localparam logic [PAT_W-1:0] PAT_STOP      = 3'd0;
    localparam logic [PAT_W-1:0] PAT_STARTUP   = 3'd1;
    localparam logic [PAT_W-1:0] PAT_SHUTDOWN  = 3'd2;
    localparam logic [PAT_W-1:0] PAT_ONE       = 3'd3;
    localparam logic [PAT_W-1:0] PAT_TWO_FAST  = 3'd4;
    localparam logic [PAT_W-1:0] PAT_TWO_SLOW  = 3'd5;
    localparam logic [PAT_W-1:0] PAT_ENTER_STP = 3'd6;
    localparam logic [PAT_W-1:0] PAT_NONE      = 3'd7;

    // item kinds carried on tuser
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PERIOD  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PERIOD = 8'd1;

    localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST  = 7'd50;
    localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RST = 7'd20;
    localparam logic [THR_W-1:0]    EXTRA_TICKS      = 9'd50;
    localparam logic [TICK_W-1:0]   TICK_MAX         = 8'hff;
    localparam logic [PULSE_W-1:0]  PULSES_ONE       = 2'd1;
    localparam logic [PULSE_W-1:0]  PULSES_TWO       = 2'd2;

    typedef struct packed {
        logic [PAT_W-1:0]   active;
        logic [PAT_W-1:0]   started;
        logic [TICK_W-1:0]  ticks;
        logic [PULSE_W-1:0] pulses;
        logic               motor;
    } t_state;

    typedef struct packed {
        logic [PERIOD_W-1:0] long_period;
        logic [PERIOD_W-1:0] short_period;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic power_off;
        logic motor_on;
    } t_result;

endpackage

>>> design/haptic_vibration_pattern_generator.sv
// Haptic vibration pattern generator: one result per tick or pattern request.
// Result registered, valid in the cycle after its input is accepted; one item per cycle
// unless the output stalls, set by the single pattern update before the output register.
// An item is taken while a result is held if the result leaves in the same cycle.
// Synchronous active-low reset: startup pattern armed, motor off, periods 50 and 20.
`timescale 1ns / 1ps
module haptic_vibration_pattern_generator
    import hvpg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [2:0] pattern
    input  logic                 s_axis_tuser,   // [0] op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [0] motor_on, [1] power_off_request,
                                                 // [2] busy_res
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PERIOD_W-1:0]  i_cfg_data
);

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    accept;

    hvpg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hvpg_core u_core (
        .i_state   (r_state),
        .i_cfg     (cfg),
        .i_op      (s_axis_tuser),
        .i_pattern (s_axis_tdata[PAT_W-1:0]),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.active  <= PAT_STARTUP;
            r_state.started <= PAT_NONE;
            r_state.ticks   <= '0;
            r_state.pulses  <= '0;
            r_state.motor   <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            // hold the result until the transaction on the output completes
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b00000, r_result.busy, r_result.power_off, r_result.motor_on};

endmodule

>>> design/hvpg_cfg.sv
// Configuration registers: long and short phase periods.
// Depends on hvpg_pkg.
`timescale 1ns / 1ps
module hvpg_cfg
    import hvpg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PERIOD_W-1:0]  i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_period  <= LONG_PERIOD_RST;
            r_cfg.short_period <= SHORT_PERIOD_RST;
        end else if (i_cfg_valid) begin
            // writes to unknown indexes are dropped
            if (i_cfg_index == CFG_LONG_PERIOD) begin
                r_cfg.long_period <= i_cfg_data;
            end
            if (i_cfg_index == CFG_SHORT_PERIOD) begin
                r_cfg.short_period <= i_cfg_data;
            end
        end
    end

endmodule

>>> design/hvpg_core.sv
// Next-state and result logic for one tick or pattern request.
// Purely combinational; depends on hvpg_pkg.
`timescale 1ns / 1ps
module hvpg_core
    import hvpg_pkg::*;
(
    input  t_state           i_state,
    input  t_cfg             i_cfg,
    input  logic             i_op,
    input  logic [PAT_W-1:0] i_pattern,
    output t_state           o_state,
    output t_result          o_result
);

    t_state           s;
    logic             power_off;
    logic             is_pulse;
    logic [PULSE_W-1:0] load_count;
    logic [PULSE_W-1:0] dec_pulses;
    logic [THR_W-1:0] lp;
    logic [THR_W-1:0] sp;
    logic [THR_W-1:0] t9;
    logic [THR_W-1:0] on_end;
    logic [THR_W-1:0] off_end;
    logic [THR_W-1:0] long_end;

    assign lp = {2'b00, i_cfg.long_period};
    assign sp = {2'b00, i_cfg.short_period};

    always_comb begin
        s          = i_state;
        power_off  = 1'b0;
        is_pulse   = 1'b0;
        load_count = PULSES_ONE;
        on_end     = sp;
        off_end    = sp + 9'd1;
        long_end   = lp + EXTRA_TICKS;
        dec_pulses = '0;
        t9         = '0;

        // apply the item: a request other than PAT_NONE swaps the pattern, a tick advances the saturating counter
        if (i_op == OP_REQUEST) begin
            if (i_pattern != PAT_NONE) begin
                s.active = i_pattern;
            end
        end else if (s.ticks != TICK_MAX) begin
            s.ticks = s.ticks + 8'd1;
        end

        unique case (s.active)
            PAT_STARTUP, PAT_SHUTDOWN: begin
                if (s.active == PAT_SHUTDOWN) begin
                    long_end = {lp[THR_W-2:0], 1'b0} + EXTRA_TICKS;
                end
                if (s.active != s.started) begin
                    s.started = s.active;
                    s.ticks   = '0;
                end
                t9 = {1'b0, s.ticks};
                if (t9 < long_end) begin
                    s.motor = 1'b1;
                end else begin
                    power_off = (s.active == PAT_SHUTDOWN);
                    s.motor   = 1'b0;
                    s.active  = PAT_STOP;
                    s.started = PAT_NONE;
                end
            end
            PAT_ONE, PAT_TWO_FAST, PAT_TWO_SLOW: begin
                is_pulse = 1'b1;
                if (s.active == PAT_TWO_FAST) begin
                    load_count = PULSES_TWO;
                    off_end    = {sp[THR_W-2:0], 1'b0};
                end else if (s.active == PAT_TWO_SLOW) begin
                    load_count = PULSES_TWO;
                    on_end     = lp;
                    off_end    = {lp[THR_W-2:0], 1'b0};
                end
                if (s.active != s.started) begin
                    s.started = s.active;
                    s.ticks   = '0;
                    s.pulses  = load_count;
                end
                t9 = {1'b0, s.ticks};
                if (t9 < on_end) begin
                    s.motor = 1'b1;
                end else if (t9 < off_end) begin
                    s.motor = 1'b0;
                end else begin
                    // period over: count down, finish when the last pulse is done
                    dec_pulses = s.pulses - 2'd1;
                    s.pulses   = dec_pulses;
                    if (dec_pulses == '0) begin
                        s.motor   = 1'b0;
                        s.active  = PAT_STOP;
                        s.started = PAT_NONE;
                    end else begin
                        s.ticks = '0;
                    end
                end
            end
            PAT_ENTER_STP: begin
                s.motor  = 1'b0;
                s.active = PAT_STOP;
            end
            default: begin
                s.motor = 1'b0;
            end
        endcase
    end

    assign o_state            = s;
    assign o_result.motor_on  = s.motor;
    assign o_result.power_off = power_off & ~is_pulse;
    assign o_result.busy      = (s.active != PAT_STOP);

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for haptic_vibration_pattern_generator.
// Drives ticks and pattern requests over the input stream, predicts each result
// in place, and checks the output stream. Depends on hvpg_pkg and the design.
`timescale 1ns / 1ps
module tb_top;
    import hvpg_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int NUM_PHASES     = 9;
    localparam int PHASE_ITEMS    = 142;

    typedef struct packed {
        logic             op;
        logic [PAT_W-1:0] pattern;
    } t_hv_item;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;    // [2:0] pattern
    logic                 s_axis_tuser  = 1'b0;  // [0] op
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;          // [0] motor_on, [1] power_off, [2] busy
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [PERIOD_W-1:0]  i_cfg_data    = '0;

    haptic_vibration_pattern_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the pattern engine state and its period registers.
    logic [PAT_W-1:0]    st_active  = PAT_STARTUP;
    logic [PAT_W-1:0]    st_started = PAT_NONE;
    logic [TICK_W-1:0]   st_ticks   = '0;
    logic [PULSE_W-1:0]  st_pulses  = '0;
    logic                st_motor   = 1'b0;
    logic [PERIOD_W-1:0] cfg_long   = LONG_PERIOD_RST;
    logic [PERIOD_W-1:0] cfg_short  = SHORT_PERIOD_RST;

    t_hv_item pending_items[$];
    t_result  expected_drive[$];
    t_hv_item drv_item;

    int items_queued  = 0;
    int item_cap      = 1 << 30;
    int items_sent    = 0;
    int results_seen  = 0;
    int power_offs    = 0;
    int err_count     = 0;
    int hold_reqs     = 0;
    int holds_taken   = 0;
    bit src_idle_on   = 1'b1;
    bit snk_idle_on   = 1'b1;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function void arm_pattern(bit load, logic [PULSE_W-1:0] count);
        if (st_active != st_started) begin
            st_started = st_active;
            st_ticks   = '0;
            if (load) st_pulses = count;
        end
    endfunction

    function void end_pattern();
        st_motor   = 1'b0;
        st_active  = PAT_STOP;
        st_started = PAT_NONE;
    endfunction

    function void run_pulse(logic [THR_W-1:0] on_end, logic [THR_W-1:0] off_end);
        if (THR_W'(st_ticks) < on_end) begin
            st_motor = 1'b1;
        end else if (THR_W'(st_ticks) < off_end) begin
            st_motor = 1'b0;
        end else begin
            st_pulses = st_pulses - 1'b1;
            if (st_pulses == '0) end_pattern();
            else st_ticks = '0;
        end
    endfunction

    // Advance the shadow engine by one item and return the drive it produces.
    function t_result motor_step(t_hv_item it);
        t_result          res;
        logic [THR_W-1:0] lp;
        logic [THR_W-1:0] sp;
        res.power_off = 1'b0;
        lp = THR_W'(cfg_long);
        sp = THR_W'(cfg_short);
        if (it.op == OP_REQUEST) begin
            if (it.pattern != PAT_NONE) st_active = it.pattern;
        end else if (st_ticks != TICK_MAX) begin
            st_ticks = st_ticks + 1'b1;
        end
        case (st_active)
            PAT_STARTUP: begin
                arm_pattern(1'b0, '0);
                if (THR_W'(st_ticks) < lp + EXTRA_TICKS) st_motor = 1'b1;
                else end_pattern();
            end
            PAT_SHUTDOWN: begin
                arm_pattern(1'b0, '0);
                if (THR_W'(st_ticks) < (lp << 1) + EXTRA_TICKS) begin
                    st_motor = 1'b1;
                end else begin
                    end_pattern();
                    res.power_off = 1'b1;
                end
            end
            PAT_ONE: begin
                arm_pattern(1'b1, PULSES_ONE);
                run_pulse(sp, sp + 1'b1);
            end
            PAT_TWO_FAST: begin
                arm_pattern(1'b1, PULSES_TWO);
                run_pulse(sp, sp << 1);
            end
            PAT_TWO_SLOW: begin
                arm_pattern(1'b1, PULSES_TWO);
                run_pulse(lp, lp << 1);
            end
            PAT_ENTER_STP: begin
                st_motor  = 1'b0;
                st_active = PAT_STOP;
            end
            default: st_motor = 1'b0;
        endcase
        res.motor_on = st_motor;
        res.busy     = (st_active != PAT_STOP);
        return res;
    endfunction

    // Input driver: present queued items with random gaps between transactions.
    int src_gap = 0;
    always @(posedge i_clk) begin : drive_input
        logic nxt_valid;
        nxt_valid = s_axis_tvalid;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_drive.push_back(motor_step(drv_item));
                items_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_items.size() > 0) begin
                    drv_item     = pending_items.pop_front();
                    nxt_valid    = 1'b1;
                    s_axis_tdata <= {5'b0, drv_item.pattern};
                    s_axis_tuser <= drv_item.op;
                    src_gap      = src_idle_on ? pick_gap() : 0;
                end
            end
            s_axis_tvalid <= nxt_valid;
        end
    end

    // Output ready: random stalls, plus a long hold when one is requested.
    int hold_left  = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin : drive_ready
        logic rdy;
        int   g;
        rdy = 1'b1;
        if (i_rst_n) begin
            if (hold_reqs != holds_taken) begin
                holds_taken++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (snk_idle_on) begin
                g = pick_gap();
                if (g > 0) begin
                    stall_left = g - 1;
                    rdy = 1'b0;
                end
            end
            m_axis_tready <= rdy;
        end
    end

    task automatic log_mismatch(string what, t_result exp_r, logic [2:0] act);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected motor=%0b pwr_off=%0b busy=%0b",
                     $time, what, exp_r.motor_on, exp_r.power_off, exp_r.busy);
            $display("    got motor=%0b pwr_off=%0b busy=%0b", act[0], act[1], act[2]);
        end
    endtask

    // Output monitor: compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin : check_output
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_drive.size() == 0) begin
                exp_r = '0;
                log_mismatch("unexpected result", exp_r, m_axis_tdata[2:0]);
            end else begin
                exp_r = expected_drive.pop_front();
                if (exp_r.power_off) power_offs++;
                if (m_axis_tdata[0] !== exp_r.motor_on ||
                    m_axis_tdata[1] !== exp_r.power_off ||
                    m_axis_tdata[2] !== exp_r.busy)
                    log_mismatch("result mismatch", exp_r, m_axis_tdata[2:0]);
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_drive.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Queue one item; drop it once the current phase has its share.
    function void push_item(logic op, logic [PAT_W-1:0] pat);
        t_hv_item it;
        if (items_queued >= item_cap) return;
        it.op      = op;
        it.pattern = pat;
        pending_items.push_back(it);
        items_queued++;
    endfunction

    function void push_ticks(int n);
        repeat (n) push_item(OP_TICK, PAT_W'($urandom));
    endfunction

    // One stimulus sequence: a request followed by a run of ticks, an interrupted
    // and resumed pattern, or a burst of random noise.
    function void gen_sequence();
        int               r;
        int               span;
        logic [PAT_W-1:0] pat;
        span = 2 * cfg_long + 2 * cfg_short + 60;
        if (span > 320) span = 320;
        r   = $urandom_range(0, 99);
        pat = PAT_W'($urandom_range(0, 7));
        if (r < 70) begin
            push_item(OP_REQUEST, pat);
            push_ticks($urandom_range(0, span));
        end else if (r < 85) begin
            push_item(OP_REQUEST, pat);
            push_ticks($urandom_range(0, span / 2));
            push_item(OP_REQUEST, $urandom_range(0, 1) ? PAT_STOP : PAT_ENTER_STP);
            push_ticks($urandom_range(0, 5));
            push_item(OP_REQUEST, pat);
            push_ticks($urandom_range(0, span));
        end else begin
            repeat ($urandom_range(1, 8))
                push_item(logic'($urandom_range(0, 1)), PAT_W'($urandom_range(0, 7)));
        end
    endfunction

    // Wait until every queued item has come back as a result.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (results_seen < items_queued);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_LONG_PERIOD) cfg_long = val;
        else cfg_short = val;
    endtask

    initial begin : stimulus
        logic [PERIOD_W-1:0] lp_sched[NUM_PHASES];
        logic [PERIOD_W-1:0] sp_sched[NUM_PHASES];
        int                  ph;
        int                  start_cnt;

        lp_sched = '{7'd50, 7'd1, 7'd0, 7'd127, 7'd100, 7'd103, 7'd4, 7'd0, 7'd0};
        sp_sched = '{7'd20, 7'd1, 7'd0, 7'd127, 7'd100, 7'd5,   7'd3, 7'd0, 7'd0};
        lp_sched[7] = PERIOD_W'($urandom_range(1, 12));
        sp_sched[7] = PERIOD_W'($urandom_range(1, 12));
        lp_sched[8] = PERIOD_W'($urandom_range(0, 127));
        sp_sched[8] = PERIOD_W'($urandom_range(0, 127));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: startup after reset, no restart of a running pattern, resume after
        // stop, the unused pattern code, and every request code at least once.
        push_ticks(2);
        push_item(OP_REQUEST, PAT_STARTUP);
        push_ticks(1);
        push_item(OP_REQUEST, PAT_ONE);
        push_ticks(1);
        push_item(OP_REQUEST, PAT_STOP);
        push_ticks(1);
        push_item(OP_REQUEST, PAT_ONE);
        push_ticks(1);
        push_item(OP_REQUEST, PAT_NONE);
        push_item(OP_REQUEST, PAT_ENTER_STP);
        push_ticks(1);
        push_item(OP_REQUEST, PAT_TWO_FAST);
        push_ticks(1);
        push_item(OP_REQUEST, PAT_TWO_SLOW);
        push_ticks(1);
        push_item(OP_REQUEST, PAT_SHUTDOWN);
        push_ticks(2);
        push_item(OP_REQUEST, PAT_ENTER_STP);
        push_ticks(1);
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            repeat (2) @(posedge i_clk);
            write_cfg(CFG_LONG_PERIOD, lp_sched[ph]);
            write_cfg(CFG_SHORT_PERIOD, sp_sched[ph]);
            src_idle_on = (ph % 3 != 2);
            snk_idle_on = (ph % 4 != 3);
            start_cnt = items_queued;
            item_cap  = start_cnt + PHASE_ITEMS;
            while (items_queued < start_cnt + PHASE_ITEMS / 2) gen_sequence();
            // hold the output while the sender keeps offering, so the input backs up
            if (ph == 4) hold_reqs++;
            // let everything in flight drain before the second half of the phase
            if (ph == 6) wait_drained();
            while (items_queued < start_cnt + PHASE_ITEMS) gen_sequence();
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        err_count += expected_drive.size();
        $display("Ran %0d items through %0d period settings, with stalls on both sides.",
                 items_sent, NUM_PHASES);
        $display("Checked %0d results, %0d of them power-off pulses.",
                 results_seen, power_offs);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> files.f
design/hvpg_pkg.sv
design/hvpg_cfg.sv
design/hvpg_core.sv
design/haptic_vibration_pattern_generator.sv
tb/tb_top.sv
